/* design/erld_pkg.sv */
package erld_pkg;

	localparam int BYTE_W    = 8;
	localparam int WORD_W    = 64;
	localparam int SPC_W     = 8;
	localparam int NIB_W     = 4;
	localparam int CFG_IDX_W = 1;

	localparam logic [CFG_IDX_W-1:0] REG_PART_START = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SECT_PER_CLU = 1'd1;

	localparam logic [SPC_W-1:0] SPC_RESET = 8'd8;

	typedef struct packed {
		logic              ext;
		logic [WORD_W-1:0] cluster;
		logic [WORD_W-1:0] length;
		logic              done;
		logic              found;
	} res_t;

endpackage

/* design/erld_in_if.sv */
interface erld_in_if;
	logic                         valid;
	logic                         ready;
	logic [erld_pkg::BYTE_W-1:0]  run_byte;
	logic                         last_byte;

	modport source (output valid, output run_byte, output last_byte, input ready);
	modport sink (input valid, input run_byte, input last_byte, output ready);
endinterface

/* design/erld_out_if.sv */
interface erld_out_if;
	logic                         valid;
	logic                         ready;
	logic                         extent_valid;
	logic [erld_pkg::WORD_W-1:0]  ext_start;
	logic [erld_pkg::WORD_W-1:0]  ext_sectors;
	logic                         list_done;
	logic                         found_any;

	modport source (output valid, output extent_valid, output ext_start,
		output ext_sectors, output list_done, output found_any, input ready);
	modport sink (input valid, input extent_valid, input ext_start,
		input ext_sectors, input list_done, input found_any, output ready);
endinterface

/* design/erld_cfg_if.sv */
interface erld_cfg_if;
	logic                            valid;
	logic                            ready;
	logic [erld_pkg::CFG_IDX_W-1:0]  index;
	logic [erld_pkg::WORD_W-1:0]     data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

/* design/erld_decode.sv */
module erld_decode (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          rb_valid,
	output logic                          rb_ready,
	input  logic [erld_pkg::BYTE_W-1:0]   rb_byte,
	input  logic                          rb_last,
	output logic                          dn_valid,
	input  logic                          dn_ready,
	output erld_pkg::res_t                dn_res
);
	import erld_pkg::*;

	typedef enum logic [1:0] {
		PH_HEADER,
		PH_LENGTH,
		PH_OFFSET,
		PH_DRAIN
	} phase_t;

	phase_t              phase_q, phase_n;
	logic [NIB_W-1:0]    idx_q, idx_n, idx_inc;
	logic [NIB_W-1:0]    lsz_q, lsz_n, osz_q, osz_n;
	logic [WORD_W-1:0]   len_q, len_n, off_q, off_n, clu_q, clu_n;
	logic                any_q, any_n;

	logic                v_s1;
	logic [BYTE_W-1:0]   byte_s1;
	logic                last_s1;
	logic                v_s2;
	res_t                res_s2;

	logic                consume;
	logic [WORD_W-1:0]   fill;
	logic [WORD_W-1:0]   off_v;
	logic [WORD_W-1:0]   off_ext;
	logic [WORD_W-1:0]   sum;
	logic                sign;
	logic                pos;
	logic                fin;
	logic                ext;
	logic                has_res;
	res_t                res_n;

	assign consume  = v_s1 && (!v_s2 || dn_ready);
	assign rb_ready = !v_s1 || consume;
	assign dn_valid = v_s2;
	assign dn_res   = res_s2;

	assign idx_inc = idx_q + 4'd1;
	assign fill    = {56'd0, byte_s1} << {idx_q[2:0], 3'b000};
	assign off_v   = idx_q[3] ? off_q : (off_q | fill);
	assign sign    = off_v[{osz_q[2:0] - 3'd1, 3'b111}];

	// sign extension from the top kept byte of the offset
	always_comb begin
		off_ext = off_v;
		for (int j = 0; j < 8; j++) begin
			if (!osz_q[3] && (4'(j) >= osz_q) && sign) begin
				off_ext[j*8 +: 8] = 8'hFF;
			end
		end
	end

	assign sum = clu_q + off_ext;
	assign pos = (sum != '0) && !sum[WORD_W-1];

	always_comb begin
		phase_n = phase_q;
		idx_n   = idx_q;
		lsz_n   = lsz_q;
		osz_n   = osz_q;
		len_n   = len_q;
		off_n   = off_q;
		clu_n   = clu_q;
		any_n   = any_q;
		fin     = 1'b0;
		ext     = 1'b0;
		case (phase_q)
			PH_HEADER: begin
				lsz_n = byte_s1[3:0];
				osz_n = byte_s1[7:4];
				if (byte_s1[3:0] == '0 || byte_s1[7:4] == '0 || last_s1) begin
					fin = 1'b1;
				end else begin
					len_n   = '0;
					off_n   = '0;
					idx_n   = '0;
					phase_n = PH_LENGTH;
				end
			end
			PH_LENGTH: begin
				if (!idx_q[3]) begin
					len_n = len_q | fill;
				end
				idx_n = idx_inc;
				if (last_s1) begin
					fin = 1'b1;
				end else if (idx_inc >= lsz_q) begin
					idx_n   = '0;
					phase_n = PH_OFFSET;
				end
			end
			PH_OFFSET: begin
				off_n = off_v;
				idx_n = idx_inc;
				if (idx_inc < osz_q) begin
					fin = last_s1;
				end else begin
					// run complete
					off_n   = off_ext;
					clu_n   = sum;
					idx_n   = '0;
					phase_n = PH_HEADER;
					if (pos) begin
						ext   = 1'b1;
						any_n = 1'b1;
					end
					fin = last_s1;
				end
			end
			default: begin
			end
		endcase

		res_n.ext     = ext;
		res_n.cluster = sum;
		res_n.length  = len_q;
		res_n.done    = fin;
		res_n.found   = fin && any_n;
		has_res       = ext || fin;

		if (fin && !last_s1) begin
			phase_n = PH_DRAIN;
		end
		if (last_s1 && (fin || phase_q == PH_DRAIN)) begin
			phase_n = PH_HEADER;
			idx_n   = '0;
			lsz_n   = '0;
			osz_n   = '0;
			len_n   = '0;
			off_n   = '0;
			clu_n   = '0;
			any_n   = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HEADER;
			idx_q   <= '0;
			lsz_q   <= '0;
			osz_q   <= '0;
			len_q   <= '0;
			off_q   <= '0;
			clu_q   <= '0;
			any_q   <= 1'b0;
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
		end else begin
			if (rb_ready) begin
				v_s1 <= rb_valid;
			end
			if (consume) begin
				phase_q <= phase_n;
				idx_q   <= idx_n;
				lsz_q   <= lsz_n;
				osz_q   <= osz_n;
				len_q   <= len_n;
				off_q   <= off_n;
				clu_q   <= clu_n;
				any_q   <= any_n;
				v_s2    <= has_res;
			end else if (dn_ready) begin
				v_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rb_valid && rb_ready) begin
			byte_s1 <= rb_byte;
			last_s1 <= rb_last;
		end
		if (consume) begin
			res_s2 <= res_n;
		end
	end

endmodule

/* design/erld_scale.sv */
module erld_scale (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [erld_pkg::WORD_W-1:0]   part_start,
	input  logic [erld_pkg::SPC_W-1:0]    sect_per_clu,
	input  logic                          up_valid,
	output logic                          up_ready,
	input  erld_pkg::res_t                up_res,
	erld_out_if.source                    extents
);
	import erld_pkg::*;

	logic                v_s3;
	logic                ext_s3, done_s3, found_s3;
	logic [WORD_W-1:0]   prodc_s3, prodl_s3;
	logic                ov_q;
	logic                ext_q, done_q, found_q;
	logic [WORD_W-1:0]   start_q, count_q;
	logic                adv3;
	logic [WORD_W-1:0]   spc_w;

	assign spc_w    = {{(WORD_W-SPC_W){1'b0}}, sect_per_clu};
	assign adv3     = !ov_q || extents.ready;
	assign up_ready = !v_s3 || adv3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
			ov_q <= 1'b0;
		end else begin
			if (up_ready) begin
				v_s3 <= up_valid;
			end
			if (adv3) begin
				ov_q <= v_s3;
			end
		end
	end

	// cluster and length scaled to sectors, then offset by partition start
	always_ff @(posedge clk) begin
		if (up_valid && up_ready) begin
			prodc_s3 <= up_res.cluster * spc_w;
			prodl_s3 <= up_res.length * spc_w;
			ext_s3   <= up_res.ext;
			done_s3  <= up_res.done;
			found_s3 <= up_res.found;
		end
		if (adv3 && v_s3) begin
			ext_q   <= ext_s3;
			done_q  <= done_s3;
			found_q <= found_s3;
			start_q <= ext_s3 ? (part_start + prodc_s3) : '0;
			count_q <= ext_s3 ? prodl_s3 : '0;
		end
	end

	assign extents.valid        = ov_q;
	assign extents.extent_valid = ext_q;
	assign extents.ext_start    = start_q;
	assign extents.ext_sectors  = count_q;
	assign extents.list_done    = done_q;
	assign extents.found_any    = found_q;

endmodule

/* design/extent_run_list_decoder_unit.sv */
// pipeline: a run list byte is registered in s1, decoded into the s2 result, scaled in s3 and
// offset into the output register; throughput: one run list byte per cycle unless the output stalls;
// the decode stage updates its run state once per byte and the 64-bit running cluster sum once per run
// reset: arst_n clears all run state and pipeline valids at once, partition start
// to zero and sectors per cluster to eight; no clearing pass
module extent_run_list_decoder_unit (
	input  logic          clk,
	input  logic          arst_n,
	erld_in_if.sink       runs,
	erld_out_if.source    extents,
	erld_cfg_if.sink      cfg
);
	import erld_pkg::*;

	logic [WORD_W-1:0]  part_start_q;
	logic [SPC_W-1:0]   spc_q;
	logic               s2_valid, s2_ready;
	res_t               s2_res;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			part_start_q <= '0;
			spc_q        <= SPC_RESET;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_PART_START:   part_start_q <= cfg.data;
				REG_SECT_PER_CLU: spc_q        <= cfg.data[SPC_W-1:0];
				default: begin
				end
			endcase
		end
	end

	erld_decode u_decode (
		.clk      (clk),
		.arst_n   (arst_n),
		.rb_valid (runs.valid),
		.rb_ready (runs.ready),
		.rb_byte  (runs.run_byte),
		.rb_last  (runs.last_byte),
		.dn_valid (s2_valid),
		.dn_ready (s2_ready),
		.dn_res   (s2_res)
	);

	erld_scale u_scale (
		.clk          (clk),
		.arst_n       (arst_n),
		.part_start   (part_start_q),
		.sect_per_clu (spc_q),
		.up_valid     (s2_valid),
		.up_ready     (s2_ready),
		.up_res       (s2_res),
		.extents      (extents)
	);

endmodule

/* design/erld_checker.sv */
module erld_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          out_valid,
	input  logic                          out_ready,
	input  logic                          extent_valid,
	input  logic [erld_pkg::WORD_W-1:0]   ext_start,
	input  logic [erld_pkg::WORD_W-1:0]   ext_sectors,
	input  logic                          list_done,
	input  logic                          found_any
);

	// a stalled word holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result word dropped while stalled");

	// every word carries an extent or an end of list
	a_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> extent_valid || list_done)
		else $error("empty result word");

	a_zero_fields: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !extent_valid |-> ext_start == '0 && ext_sectors == '0)
		else $error("extent fields set without extent");

	a_found_done: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !list_done |-> !found_any)
		else $error("found flag without end of list");

	a_found_ext: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && list_done && extent_valid |-> found_any)
		else $error("extent at end of list not counted as found");

endmodule

bind extent_run_list_decoder_unit erld_checker u_chk (
	.clk          (clk),
	.arst_n       (arst_n),
	.out_valid    (extents.valid),
	.out_ready    (extents.ready),
	.extent_valid (extents.extent_valid),
	.ext_start    (extents.ext_start),
	.ext_sectors  (extents.ext_sectors),
	.list_done    (extents.list_done),
	.found_any    (extents.found_any)
);
